>>> sv/assert_macros.svh
// Assertion macros shared by the route marker sequencer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked at every clock edge out of reset.
`define RMS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

>>> sv/rms_pkg.sv
// Package for the route marker sequencer: code ranges, zone width, request, marker and
// action codes, and plan types. No dependencies; used through scoped names.
`timescale 1ns / 1ps

package rms_pkg;

    localparam int POSITION_BASE  = 1;
    localparam int POSITION_COUNT = 8;
    localparam int ROUTE_BASE     = 1;
    localparam int ROUTE_COUNT    = 8;

    localparam int MAX_COUNT = (POSITION_COUNT > ROUTE_COUNT) ? POSITION_COUNT : ROUTE_COUNT;
    localparam int ZONE_W    = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;

    typedef logic [ZONE_W-1:0] t_zone;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        REQ_START    = 2'd0,
        REQ_MARKER   = 2'd1,
        REQ_LOAD_ON  = 2'd2,
        REQ_LOAD_OFF = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        MK_NONE   = 3'd0,
        MK_SOURCE = 3'd1,
        MK_COMMON = 3'd2,
        MK_PICKUP = 3'd3,
        MK_TARGET = 3'd4,
        MK_DEST   = 3'd5
    } t_marker;

    typedef enum logic [3:0] {
        ACT_NONE        = 4'd0,
        ACT_STRAIGHT    = 4'd1,
        ACT_LEFT        = 4'd2,
        ACT_RIGHT       = 4'd3,
        ACT_TURN_AROUND = 4'd4,
        ACT_STOP_PICKUP = 4'd5,
        ACT_STOP_DEST   = 4'd6,
        ACT_LOAD_LOST   = 4'd7,
        ACT_COMPLETE    = 4'd8,
        ACT_ERROR       = 4'd9
    } t_action;

    typedef struct packed {
        logic  ok;
        t_zone target;
        t_dir  dir;
        t_zone junctions;
    } t_plan;

endpackage

>>> sv/rms_channels.sv
// Request and result channel interfaces of the route marker sequencer.
// Valid/ready handshake; no package dependencies.
`timescale 1ns / 1ps

interface rms_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] start_position;
    logic [7:0] route_code;

    modport source (output valid, req_type, start_position, route_code, input ready);
    modport sink   (input valid, req_type, start_position, route_code, output ready);
endinterface

interface rms_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] action;
    logic       plan_accepted;
    logic       dest_valid;
    logic [7:0] dest_position;
    logic [3:0] phase_now;

    modport source (output valid, action, plan_accepted, dest_valid, dest_position,
                    phase_now, input ready);
    modport sink   (input valid, action, plan_accepted, dest_valid, dest_position,
                    phase_now, output ready);
endinterface

>>> sv/rms_plan.sv
// Start-job decoder: range checks the raw codes, derives turn direction and junction count.
// Depends on rms_pkg.
`timescale 1ns / 1ps

module rms_plan (
    input  logic [7:0]    i_start_position,
    input  logic [7:0]    i_route_code,
    output rms_pkg::t_plan o_plan
);

    function automatic logic [rms_pkg::ZONE_W:0] to_zone(input logic [7:0] code,
                                                         input logic [8:0] base,
                                                         input logic [8:0] count);
        logic [8:0] diff;
        logic       ok;
        diff = {1'b0, code} - base;
        ok   = ({1'b0, code} >= base) && (diff < count);
        return {ok, diff[rms_pkg::ZONE_W-1:0]};
    endfunction

    logic [rms_pkg::ZONE_W:0] w_org;
    logic [rms_pkg::ZONE_W:0] w_tgt;
    rms_pkg::t_zone           w_oz;
    rms_pkg::t_zone           w_tz;

    assign w_org = to_zone(i_start_position, 9'(rms_pkg::POSITION_BASE),
                           9'(rms_pkg::POSITION_COUNT));
    assign w_tgt = to_zone(i_route_code, 9'(rms_pkg::ROUTE_BASE),
                           9'(rms_pkg::ROUTE_COUNT));
    assign w_oz  = w_org[rms_pkg::ZONE_W-1:0];
    assign w_tz  = w_tgt[rms_pkg::ZONE_W-1:0];

    always_comb begin
        o_plan.ok     = w_org[rms_pkg::ZONE_W] && w_tgt[rms_pkg::ZONE_W];
        o_plan.target = w_tz;
        priority if (w_tz > w_oz) begin
            o_plan.dir       = rms_pkg::DIR_RIGHT;
            o_plan.junctions = w_tz - w_oz;
        end else if (w_tz < w_oz) begin
            o_plan.dir       = rms_pkg::DIR_LEFT;
            o_plan.junctions = w_oz - w_tz;
        end else begin
            o_plan.dir       = rms_pkg::DIR_NONE;
            o_plan.junctions = '0;
        end
    end

endmodule

>>> sv/rms_core.sv
// Sequencer state, next-state logic and result register of the route marker sequencer.
// Depends on rms_pkg, rms_channels and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rms_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_req_type,
    input  rms_pkg::t_plan i_plan,
    output logic           o_adv,
    rms_res_if.source      o_res
);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_TO_SOURCE = 4'd1,
        PH_COMMON    = 4'd2,
        PH_TO_PICKUP = 4'd3,
        PH_WAIT_LOAD = 4'd4,
        PH_TO_UNLOAD = 4'd5,
        PH_UNLOADING = 4'd6,
        PH_COMPLETE  = 4'd7,
        PH_ERROR     = 4'd8
    } t_phase;

    t_phase            r_phase,   n_phase;
    rms_pkg::t_dir     r_dir,     n_dir;
    rms_pkg::t_marker  r_marker,  n_marker;
    rms_pkg::t_zone    r_tgt,     n_tgt;
    logic              r_tgt_ok,  n_tgt_ok;
    rms_pkg::t_zone    r_junc,    n_junc;
    logic              r_load,    n_load;
    logic              r_plan_ok, n_plan_ok;

    rms_pkg::t_action  n_action;
    logic              n_accepted;
    logic              n_dest_valid;
    logic [7:0]        n_dest_pos;
    logic [8:0]        w_dest_sum;

    logic              r_out_valid;
    rms_pkg::t_action  r_out_action;
    logic              r_out_accepted;
    logic              r_out_dest_valid;
    logic [7:0]        r_out_dest_pos;
    t_phase            r_out_phase;

    logic              w_take;

    assign o_adv  = !r_out_valid || o_res.ready;
    assign w_take = i_in_valid && o_adv;

    always_comb begin
        logic fail;
        fail       = 1'b0;
        n_phase    = r_phase;
        n_dir      = r_dir;
        n_marker   = r_marker;
        n_tgt      = r_tgt;
        n_tgt_ok   = r_tgt_ok;
        n_junc     = r_junc;
        n_load     = r_load;
        n_plan_ok  = r_plan_ok;
        n_action   = rms_pkg::ACT_NONE;
        n_accepted = 1'b0;

        if (rms_pkg::t_req'(i_req_type) == rms_pkg::REQ_START) begin
            n_phase   = PH_IDLE;
            n_dir     = rms_pkg::DIR_NONE;
            n_marker  = rms_pkg::MK_NONE;
            n_tgt     = '0;
            n_tgt_ok  = 1'b0;
            n_junc    = '0;
            n_load    = 1'b0;
            n_plan_ok = 1'b0;
            if (i_plan.ok) begin
                n_tgt      = i_plan.target;
                n_tgt_ok   = 1'b1;
                n_dir      = i_plan.dir;
                n_junc     = i_plan.junctions;
                n_phase    = PH_TO_SOURCE;
                n_marker   = rms_pkg::MK_SOURCE;
                n_plan_ok  = 1'b1;
                n_accepted = 1'b1;
            end
        end else if (!r_plan_ok) begin
            n_action = rms_pkg::ACT_ERROR;
        end else begin
            unique case (rms_pkg::t_req'(i_req_type))
                rms_pkg::REQ_MARKER: begin
                    unique case (r_phase)
                        PH_TO_SOURCE: begin
                            if (r_marker != rms_pkg::MK_SOURCE) begin
                                fail = 1'b1;
                            end else if (r_dir == rms_pkg::DIR_NONE) begin
                                n_phase  = PH_TO_PICKUP;
                                n_marker = rms_pkg::MK_PICKUP;
                                n_action = rms_pkg::ACT_STRAIGHT;
                            end else begin
                                n_phase  = PH_COMMON;
                                n_marker = rms_pkg::MK_COMMON;
                                n_action = (r_dir == rms_pkg::DIR_RIGHT)
                                           ? rms_pkg::ACT_RIGHT : rms_pkg::ACT_LEFT;
                            end
                        end
                        PH_COMMON: begin
                            if (r_marker != rms_pkg::MK_COMMON || r_junc == '0) begin
                                fail = 1'b1;
                            end else begin
                                n_junc = r_junc - 1'b1;
                                if (r_junc != rms_pkg::t_zone'(1)) begin
                                    n_action = rms_pkg::ACT_STRAIGHT;
                                end else begin
                                    n_phase  = PH_TO_PICKUP;
                                    n_marker = rms_pkg::MK_PICKUP;
                                    n_action = (r_dir == rms_pkg::DIR_RIGHT)
                                               ? rms_pkg::ACT_LEFT : rms_pkg::ACT_RIGHT;
                                end
                            end
                        end
                        PH_TO_PICKUP: begin
                            if (r_marker != rms_pkg::MK_PICKUP) begin
                                fail = 1'b1;
                            end else begin
                                n_phase  = PH_WAIT_LOAD;
                                n_marker = rms_pkg::MK_NONE;
                                n_action = rms_pkg::ACT_STOP_PICKUP;
                            end
                        end
                        PH_TO_UNLOAD: begin
                            priority if (r_marker == rms_pkg::MK_TARGET) begin
                                n_marker = rms_pkg::MK_DEST;
                                n_action = rms_pkg::ACT_STRAIGHT;
                            end else if (r_marker == rms_pkg::MK_DEST) begin
                                n_phase  = PH_UNLOADING;
                                n_marker = rms_pkg::MK_NONE;
                                n_action = rms_pkg::ACT_STOP_DEST;
                            end else begin
                                fail = 1'b1;
                            end
                        end
                        default: begin
                            fail = 1'b1;
                        end
                    endcase
                end
                rms_pkg::REQ_LOAD_ON: begin
                    if (r_phase == PH_WAIT_LOAD && !r_load) begin
                        n_load   = 1'b1;
                        n_phase  = PH_TO_UNLOAD;
                        n_marker = rms_pkg::MK_TARGET;
                        n_action = rms_pkg::ACT_TURN_AROUND;
                    end
                end
                rms_pkg::REQ_LOAD_OFF: begin
                    priority if (r_phase == PH_TO_UNLOAD && r_load) begin
                        n_phase   = PH_ERROR;
                        n_marker  = rms_pkg::MK_NONE;
                        n_plan_ok = 1'b0;
                        n_action  = rms_pkg::ACT_LOAD_LOST;
                    end else if (r_phase == PH_UNLOADING && r_load) begin
                        n_load   = 1'b0;
                        n_phase  = PH_COMPLETE;
                        n_marker = rms_pkg::MK_NONE;
                        n_action = rms_pkg::ACT_COMPLETE;
                    end else begin
                        n_action = rms_pkg::ACT_NONE;
                    end
                end
                rms_pkg::REQ_START: begin
                    n_action = rms_pkg::ACT_NONE;
                end
            endcase
        end

        if (fail) begin
            n_phase   = PH_ERROR;
            n_marker  = rms_pkg::MK_NONE;
            n_plan_ok = 1'b0;
            n_action  = rms_pkg::ACT_ERROR;
        end
    end

    // destination follows the target zone left by this request
    assign w_dest_sum   = 9'(rms_pkg::POSITION_BASE) + 9'(n_tgt);
    assign n_dest_valid = n_tgt_ok && (9'(n_tgt) < 9'(rms_pkg::POSITION_COUNT))
                          && !w_dest_sum[8];
    assign n_dest_pos   = n_dest_valid ? w_dest_sum[7:0] : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_dir       <= rms_pkg::DIR_NONE;
            r_marker    <= rms_pkg::MK_NONE;
            r_tgt       <= '0;
            r_tgt_ok    <= 1'b0;
            r_junc      <= '0;
            r_load      <= 1'b0;
            r_plan_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_out_valid <= i_in_valid;
            end
            if (w_take) begin
                r_phase   <= n_phase;
                r_dir     <= n_dir;
                r_marker  <= n_marker;
                r_tgt     <= n_tgt;
                r_tgt_ok  <= n_tgt_ok;
                r_junc    <= n_junc;
                r_load    <= n_load;
                r_plan_ok <= n_plan_ok;
            end
        end
        if (w_take) begin
            r_out_action     <= n_action;
            r_out_accepted   <= n_accepted;
            r_out_dest_valid <= n_dest_valid;
            r_out_dest_pos   <= n_dest_pos;
            r_out_phase      <= n_phase;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.action        = r_out_action;
    assign o_res.plan_accepted = r_out_accepted;
    assign o_res.dest_valid    = r_out_dest_valid;
    assign o_res.dest_position = r_out_dest_pos;
    assign o_res.phase_now     = r_out_phase;

    `RMS_ASSERT_ALWAYS(a_no_plan_parked, i_clk, i_rst_n,
        r_plan_ok || r_phase == PH_IDLE || r_phase == PH_ERROR,
        "phase advanced without a plan")
    `RMS_ASSERT_IMP(a_straight_no_junc, i_clk, i_rst_n,
        r_dir == rms_pkg::DIR_NONE, r_junc == '0,
        "junctions pending on a straight route")
    `RMS_ASSERT_IMP(a_accept_quiet, i_clk, i_rst_n,
        r_out_valid && r_out_accepted,
        r_out_action == rms_pkg::ACT_NONE && r_out_phase == PH_TO_SOURCE,
        "accepted plan with unexpected action or phase")
    `RMS_ASSERT_IMP(a_error_phase, i_clk, i_rst_n,
        r_out_valid && r_out_action == rms_pkg::ACT_ERROR,
        r_out_phase == PH_IDLE || r_out_phase == PH_ERROR,
        "error reported outside idle or error phase")

endmodule

>>> sv/route_marker_sequencer.sv
// Route marker sequencer: takes one request per cycle (start job, marker seen, load on,
// load off) and returns exactly one result per request. A request is held in the input
// register and then moves to the result register, from which its result is offered; with the
// result side always ready the block sustains one request per cycle. The plan state updates
// as a request moves from the input register to the result register; a stalled result
// holds the result register and drops input ready once the input register is also full.
// Synchronous active-low reset returns the sequencer to idle with no plan.
// Depends on rms_pkg, rms_channels, rms_plan and rms_core.
`timescale 1ns / 1ps

module route_marker_sequencer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rms_req_if.sink   i_req,
    rms_res_if.source o_res
);

    logic           r_in_valid;
    logic [1:0]     r_req_type;
    logic [7:0]     r_start_position;
    logic [7:0]     r_route_code;
    logic           w_adv;
    rms_pkg::t_plan w_plan;

    assign i_req.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_req_type       <= i_req.req_type;
            r_start_position <= i_req.start_position;
            r_route_code     <= i_req.route_code;
        end
    end

    rms_plan u_plan (
        .i_start_position (r_start_position),
        .i_route_code     (r_route_code),
        .o_plan           (w_plan)
    );

    rms_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (r_in_valid),
        .i_req_type (r_req_type),
        .i_plan     (w_plan),
        .o_adv      (w_adv),
        .o_res      (o_res)
    );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for route_marker_sequencer: directed route jobs, then random jobs
// under sender/receiver idling and long result stalls, each result checked against a predictor.
// Depends on rms_pkg, rms_channels and the route_marker_sequencer RTL.
`timescale 1ns / 1ps

module tb_top;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_TO_SOURCE = 4'd1,
        PH_COMMON    = 4'd2,
        PH_TO_PICKUP = 4'd3,
        PH_WAIT_LOAD = 4'd4,
        PH_TO_UNLOAD = 4'd5,
        PH_UNLOADING = 4'd6,
        PH_COMPLETE  = 4'd7,
        PH_ERROR     = 4'd8
    } t_phase;

    localparam logic [4:0] ZONE_NONE   = 5'd31;
    localparam int         HOLD_CYCLES = 80;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] start_position;
        logic [7:0] route_code;
    } t_request;

    typedef struct packed {
        logic [3:0] action;
        logic       plan_accepted;
        logic       dest_valid;
        logic [7:0] dest_position;
        logic [3:0] phase_now;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rms_req_if req_ch ();
    rms_res_if res_ch ();

    route_marker_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // vehicle plan as the predictor sees it
    t_phase           veh_phase;
    rms_pkg::t_dir    veh_dir;
    rms_pkg::t_marker veh_next;
    logic [4:0]       veh_origin;
    logic [4:0]       veh_target;
    logic [4:0]       veh_junctions;
    logic             veh_loaded;
    logic             veh_plan_ok;

    t_result route_results_due[$];
    int      bad_results   = 0;
    int      sent_requests = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      hold_req      = 1'b0;
    bit      holding       = 1'b0;

    function automatic void clear_route();
        veh_phase     = PH_IDLE;
        veh_dir       = rms_pkg::DIR_NONE;
        veh_next      = rms_pkg::MK_NONE;
        veh_origin    = ZONE_NONE;
        veh_target    = ZONE_NONE;
        veh_junctions = '0;
        veh_loaded    = 1'b0;
        veh_plan_ok   = 1'b0;
    endfunction

    function automatic logic [4:0] zone_of(input logic [7:0] code, input int base, input int count);
        int         c;
        logic [4:0] z;
        c = int'(code);
        if (c < base || c - base >= count) return ZONE_NONE;
        z = 5'(c - base);
        return z;
    endfunction

    function automatic logic [3:0] abort_route();
        veh_phase   = PH_ERROR;
        veh_next    = rms_pkg::MK_NONE;
        veh_plan_ok = 1'b0;
        return rms_pkg::ACT_ERROR;
    endfunction

    function automatic t_result predict_route(input t_request r);
        t_result    res;
        logic [4:0] oz;
        logic [4:0] tz;
        logic [3:0] act;
        int         d;
        res = '0;
        act = rms_pkg::ACT_NONE;
        if (r.req_type == rms_pkg::REQ_START) begin
            oz = zone_of(r.start_position, rms_pkg::POSITION_BASE, rms_pkg::POSITION_COUNT);
            tz = zone_of(r.route_code, rms_pkg::ROUTE_BASE, rms_pkg::ROUTE_COUNT);
            clear_route();
            if (oz != ZONE_NONE && tz != ZONE_NONE) begin
                veh_origin = oz;
                veh_target = tz;
                if (tz > oz) begin
                    veh_dir       = rms_pkg::DIR_RIGHT;
                    veh_junctions = tz - oz;
                end else if (tz < oz) begin
                    veh_dir       = rms_pkg::DIR_LEFT;
                    veh_junctions = oz - tz;
                end
                veh_phase         = PH_TO_SOURCE;
                veh_next          = rms_pkg::MK_SOURCE;
                veh_plan_ok       = 1'b1;
                res.plan_accepted = 1'b1;
            end
        end else if (!veh_plan_ok) begin
            act = rms_pkg::ACT_ERROR;
        end else if (r.req_type == rms_pkg::REQ_MARKER) begin
            case (veh_phase)
                PH_TO_SOURCE: begin
                    if (veh_next != rms_pkg::MK_SOURCE) begin
                        act = abort_route();
                    end else if (veh_dir == rms_pkg::DIR_NONE) begin
                        veh_phase = PH_TO_PICKUP;
                        veh_next  = rms_pkg::MK_PICKUP;
                        act       = rms_pkg::ACT_STRAIGHT;
                    end else begin
                        veh_phase = PH_COMMON;
                        veh_next  = rms_pkg::MK_COMMON;
                        act       = (veh_dir == rms_pkg::DIR_RIGHT) ? rms_pkg::ACT_RIGHT
                                                                    : rms_pkg::ACT_LEFT;
                    end
                end
                PH_COMMON: begin
                    if (veh_next != rms_pkg::MK_COMMON || veh_junctions == 0) begin
                        act = abort_route();
                    end else begin
                        veh_junctions = veh_junctions - 1'b1;
                        if (veh_junctions != 0) begin
                            act = rms_pkg::ACT_STRAIGHT;
                        end else begin
                            veh_phase = PH_TO_PICKUP;
                            veh_next  = rms_pkg::MK_PICKUP;
                            act       = (veh_dir == rms_pkg::DIR_RIGHT) ? rms_pkg::ACT_LEFT
                                                                        : rms_pkg::ACT_RIGHT;
                        end
                    end
                end
                PH_TO_PICKUP: begin
                    if (veh_next != rms_pkg::MK_PICKUP) begin
                        act = abort_route();
                    end else begin
                        veh_phase = PH_WAIT_LOAD;
                        veh_next  = rms_pkg::MK_NONE;
                        act       = rms_pkg::ACT_STOP_PICKUP;
                    end
                end
                PH_TO_UNLOAD: begin
                    if (veh_next == rms_pkg::MK_TARGET) begin
                        veh_next = rms_pkg::MK_DEST;
                        act      = rms_pkg::ACT_STRAIGHT;
                    end else if (veh_next == rms_pkg::MK_DEST) begin
                        veh_phase = PH_UNLOADING;
                        veh_next  = rms_pkg::MK_NONE;
                        act       = rms_pkg::ACT_STOP_DEST;
                    end else begin
                        act = abort_route();
                    end
                end
                default: act = abort_route();
            endcase
        end else if (r.req_type == rms_pkg::REQ_LOAD_ON) begin
            if (veh_phase == PH_WAIT_LOAD && !veh_loaded) begin
                veh_loaded = 1'b1;
                veh_phase  = PH_TO_UNLOAD;
                veh_next   = rms_pkg::MK_TARGET;
                act        = rms_pkg::ACT_TURN_AROUND;
            end
        end else begin
            if (veh_phase == PH_TO_UNLOAD && veh_loaded) begin
                veh_phase   = PH_ERROR;
                veh_next    = rms_pkg::MK_NONE;
                veh_plan_ok = 1'b0;
                act         = rms_pkg::ACT_LOAD_LOST;
            end else if (veh_phase == PH_UNLOADING && veh_loaded) begin
                veh_loaded = 1'b0;
                veh_phase  = PH_COMPLETE;
                veh_next   = rms_pkg::MK_NONE;
                act        = rms_pkg::ACT_COMPLETE;
            end
        end
        if (veh_target != ZONE_NONE && veh_target < rms_pkg::POSITION_COUNT) begin
            d = rms_pkg::POSITION_BASE + veh_target;
            if (d <= 255) begin
                res.dest_valid    = 1'b1;
                res.dest_position = d[7:0];
            end
        end
        res.action    = act;
        res.phase_now = veh_phase;
        return res;
    endfunction

    // drive at the falling edge, accept at the rising edge; valid stays up after return
    task automatic send_request(input t_request r);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid          = 1'b1;
        req_ch.req_type       = r.req_type;
        req_ch.start_position = r.start_position;
        req_ch.route_code     = r.route_code;
        do @(posedge i_clk); while (!req_ch.ready);
        route_results_due.push_back(predict_route(r));
        sent_requests++;
    endtask

    function automatic t_request random_request();
        t_request r;
        r.req_type       = 2'($urandom_range(0, 3));
        r.start_position = 8'($urandom_range(0, 255));
        r.route_code     = 8'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic send_event(input rms_pkg::t_req kind);
        t_request r;
        r          = random_request();
        r.req_type = kind;
        send_request(r);
    endtask

    task automatic send_start(input logic [7:0] sp, input logic [7:0] tr);
        t_request r;
        r.req_type       = rms_pkg::REQ_START;
        r.start_position = sp;
        r.route_code     = tr;
        send_request(r);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (route_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one job: mostly the expected event for the current phase, some noise and early aborts
    task automatic send_job();
        t_request r;
        int       steps;
        if ($urandom_range(0, 9) == 0) begin
            r = random_request();
            r.req_type = rms_pkg::REQ_START;
            send_request(r);
        end else begin
            send_start(8'(rms_pkg::POSITION_BASE
                          + $urandom_range(0, rms_pkg::POSITION_COUNT - 1)),
                       8'(rms_pkg::ROUTE_BASE
                          + $urandom_range(0, rms_pkg::ROUTE_COUNT - 1)));
        end
        steps = 0;
        while (steps < 24 && veh_plan_ok && veh_phase != PH_COMPLETE) begin
            r = random_request();
            if ($urandom_range(0, 99) >= 8) begin
                if ($urandom_range(0, 99) < 4) break;
                case (veh_phase)
                    PH_WAIT_LOAD: r.req_type = rms_pkg::REQ_LOAD_ON;
                    PH_UNLOADING: r.req_type = rms_pkg::REQ_LOAD_OFF;
                    default:      r.req_type = rms_pkg::REQ_MARKER;
                endcase
            end
            send_request(r);
            steps++;
        end
        if ($urandom_range(0, 3) == 0) send_request(random_request());
    endtask

    task automatic test_directed_route();
        send_event(rms_pkg::REQ_MARKER);
        send_event(rms_pkg::REQ_LOAD_ON);
        send_event(rms_pkg::REQ_LOAD_OFF);
        send_start(8'd0, 8'd1);
        send_start(8'd9, 8'd1);
        send_start(8'd255, 8'd255);
        send_start(8'd1, 8'd0);
        send_start(8'd1, 8'd9);
        send_start(8'd3, 8'd4);
        send_event(rms_pkg::REQ_LOAD_ON);
        send_event(rms_pkg::REQ_MARKER);
        send_event(rms_pkg::REQ_MARKER);
        send_event(rms_pkg::REQ_MARKER);
        send_event(rms_pkg::REQ_LOAD_OFF);
        send_event(rms_pkg::REQ_LOAD_ON);
        send_event(rms_pkg::REQ_LOAD_ON);
        send_event(rms_pkg::REQ_MARKER);
        send_event(rms_pkg::REQ_MARKER);
        send_event(rms_pkg::REQ_LOAD_OFF);
        send_event(rms_pkg::REQ_MARKER);
        send_start(8'd8, 8'd8);
        send_event(rms_pkg::REQ_MARKER);
        send_event(rms_pkg::REQ_MARKER);
        send_event(rms_pkg::REQ_LOAD_ON);
        send_event(rms_pkg::REQ_LOAD_OFF);
        send_event(rms_pkg::REQ_LOAD_OFF);
        send_start(8'd8, 8'd1);
        send_event(rms_pkg::REQ_MARKER);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = sent_requests + count;
        while (sent_requests < stop_at) send_job();
    endtask

    // results held off while requests keep coming, so the input side must stall
    task automatic test_result_stall();
        int stop_at;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        stop_at       = sent_requests + 24;
        while (sent_requests < stop_at) send_job();
        while (hold_req) @(posedge i_clk);
        wait_drained();
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            send_job();
            wait_drained();
        end
    endtask

    initial begin
        forever begin
            wait (hold_req);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding  = 1'b0;
            hold_req = 1'b0;
        end
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready = !holding && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (route_results_due.size() == 0) begin
                $error("unexpected result: action %0d phase %0d", res_ch.action, res_ch.phase_now);
                bad_results++;
            end else begin
                want = route_results_due.pop_front();
                if (res_ch.action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, res_ch.action);
                    bad_results++;
                end
                if (res_ch.plan_accepted !== want.plan_accepted) begin
                    $error("plan_accepted: expected %0d, got %0d",
                           want.plan_accepted, res_ch.plan_accepted);
                    bad_results++;
                end
                if (res_ch.dest_valid !== want.dest_valid) begin
                    $error("dest_valid: expected %0d, got %0d", want.dest_valid, res_ch.dest_valid);
                    bad_results++;
                end
                if (res_ch.dest_position !== want.dest_position) begin
                    $error("dest_position: expected %0d, got %0d",
                           want.dest_position, res_ch.dest_position);
                    bad_results++;
                end
                if (res_ch.phase_now !== want.phase_now) begin
                    $error("phase_now: expected %0d, got %0d", want.phase_now, res_ch.phase_now);
                    bad_results++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[route_marker_sequencer] ERROR");
        $finish;
    end

    initial begin
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = rms_pkg::REQ_START;
        req_ch.start_position = '0;
        req_ch.route_code     = '0;
        clear_route();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_route();
        test_random_traffic(24, 52, 110);
        test_random_traffic(52, 24, 110);
        test_random_traffic(0, 0, 110);
        test_result_stall();
        test_sender_pause();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (bad_results == 0 && route_results_due.size() == 0) begin
            $display("[route_marker_sequencer] OK");
        end else begin
            $display("[route_marker_sequencer] ERROR");
        end
        $finish;
    end

endmodule
